>>> hw/rtl/far_pkg.sv
// Package for the fraction add and reduce unit.
// Holds widths, the payload structs and the sequencer state type.
// No dependencies.
package far_pkg;

	localparam int VALUE_BITS = 16;
	localparam int NUM_BITS   = 2 * VALUE_BITS + 1;
	localparam int DEN_BITS   = 2 * VALUE_BITS;
	localparam int CNT_BITS   = $clog2(NUM_BITS + 1);

	typedef struct packed {
		logic                  operation;
		logic [VALUE_BITS-1:0] a_num;
		logic [VALUE_BITS-1:0] a_den;
		logic [VALUE_BITS-1:0] b_num;
		logic [VALUE_BITS-1:0] b_den;
	} item_t;

	typedef struct packed {
		logic [NUM_BITS-1:0] res_num;
		logic [DEN_BITS-1:0] res_den;
		logic                is_empty;
	} result_t;

	localparam logic OP_NORMALIZE = 1'b0;
	localparam logic OP_ADD       = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_CHECK,
		ST_GCD,
		ST_DIVN_GO,
		ST_DIVN_WAIT,
		ST_DIVD_GO,
		ST_DIVD_WAIT
	} far_state_t;

endpackage

>>> hw/rtl/far_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on far_pkg for operand widths.
module far_div import far_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] dividend,
	input  logic [NUM_BITS-1:0] divisor,
	output logic                done,
	output logic [NUM_BITS-1:0] quotient
);

	logic                run_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [NUM_BITS-1:0] rem_q;
	logic [NUM_BITS-1:0] div_q;
	logic [NUM_BITS:0]   shifted;
	logic [NUM_BITS:0]   diff;
	logic                fits;

	assign shifted = {rem_q, quo_q[NUM_BITS-1]};
	assign fits    = shifted >= {1'b0, div_q};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_BITS'(NUM_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[NUM_BITS-2:0], fits};
			rem_q <= fits ? diff[NUM_BITS-1:0] : shifted[NUM_BITS-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> hw/rtl/fraction_add_reduce_unit.sv
// Top level of the fraction add and reduce unit.
// Depends on far_pkg and far_div.
//
// channel   direction  handshake          payload
// item      in         start && !busy     item_t
// result    out        done (one cycle)   result_t
//
// Normalize: an empty item or a zero numerator is answered from the check state; else the gcd
// and two divides follow. Add first forms the sum on the shared 16x16 multiplier.
// Binary gcd runs on n and d; n and d are then each divided by it on far_div.
// Busy stays high while an item is worked on; a new item is taken only when idle.
// Reset clears the sequencer; results cannot be stalled.
module fraction_add_reduce_unit import far_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    done,
	output result_t result
);

	far_state_t state_q, state_d;

	item_t               item_q;
	logic                empty_q;
	logic [NUM_BITS-1:0] n_q;
	logic [DEN_BITS-1:0] d_q;
	logic [DEN_BITS-1:0] prod_q;
	logic [NUM_BITS-1:0] x_q;
	logic [NUM_BITS-1:0] y_q;
	logic [CNT_BITS-1:0] k_q;
	logic [NUM_BITS-1:0] g_q;
	result_t             res_q;
	logic                done_q;

	logic [VALUE_BITS-1:0] mul_a;
	logic [VALUE_BITS-1:0] mul_b;
	logic [DEN_BITS-1:0]   prod_c;
	logic                  accept;
	logic                  gcd_end;
	logic                  div_start;
	logic [NUM_BITS-1:0]   div_dividend;
	logic                  div_done;
	logic [NUM_BITS-1:0]   div_quo;

	assign accept  = start && (state_q == ST_IDLE);
	assign gcd_end = (x_q == '0) || (y_q == '0);

	always_comb begin
		unique case (state_q)
			ST_MUL0: begin
				mul_a = item_q.a_num;
				mul_b = item_q.b_den;
			end
			ST_MUL1: begin
				mul_a = item_q.a_den;
				mul_b = item_q.b_num;
			end
			default: begin
				mul_a = item_q.a_den;
				mul_b = item_q.b_den;
			end
		endcase
	end

	assign prod_c = DEN_BITS'(mul_a) * DEN_BITS'(mul_b);

	assign div_start    = (state_q == ST_DIVN_GO) || (state_q == ST_DIVD_GO);
	assign div_dividend = (state_q == ST_DIVN_GO) ? n_q : {1'b0, d_q};

	far_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (g_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (item.operation == OP_ADD) ? ST_MUL0 : ST_CHECK;
				end
			end
			ST_MUL0:  state_d = ST_MUL1;
			ST_MUL1:  state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_MUL3;
			ST_MUL3:  state_d = ST_CHECK;
			ST_CHECK: begin
				state_d = (empty_q || n_q == '0) ? ST_IDLE : ST_GCD;
			end
			ST_GCD: begin
				if (gcd_end) begin
					state_d = ST_DIVN_GO;
				end
			end
			ST_DIVN_GO: state_d = ST_DIVN_WAIT;
			ST_DIVN_WAIT: begin
				if (div_done) begin
					state_d = ST_DIVD_GO;
				end
			end
			ST_DIVD_GO: state_d = ST_DIVD_WAIT;
			ST_DIVD_WAIT: begin
				if (div_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ((state_q == ST_CHECK) && (empty_q || n_q == '0))
				|| ((state_q == ST_DIVD_WAIT) && div_done);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					item_q <= item;
					if (item.operation == OP_ADD) begin
						empty_q <= (item.a_den == '0) || (item.b_den == '0);
					end else begin
						empty_q <= (item.a_den == '0);
						n_q     <= NUM_BITS'(item.a_num);
						d_q     <= DEN_BITS'(item.a_den);
					end
				end
			end
			ST_MUL0: prod_q <= prod_c;
			ST_MUL1: begin
				n_q    <= NUM_BITS'(prod_q);
				prod_q <= prod_c;
			end
			ST_MUL2: begin
				n_q    <= n_q + NUM_BITS'(prod_q);
				prod_q <= prod_c;
			end
			ST_MUL3: d_q <= prod_q;
			ST_CHECK: begin
				if (empty_q) begin
					res_q <= '{res_num: '0, res_den: '0, is_empty: 1'b1};
				end else if (n_q == '0) begin
					res_q <= '{res_num: '0, res_den: d_q, is_empty: 1'b0};
				end else begin
					x_q <= n_q;
					y_q <= {1'b0, d_q};
					k_q <= '0;
				end
			end
			ST_GCD: begin
				priority if (gcd_end) begin
					g_q <= NUM_BITS'((x_q | y_q) << k_q);
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (x_q >= y_q) begin
					x_q <= x_q - y_q;
				end else begin
					y_q <= y_q - x_q;
				end
			end
			ST_DIVN_WAIT: begin
				if (div_done) begin
					res_q.res_num <= div_quo;
				end
			end
			ST_DIVD_WAIT: begin
				if (div_done) begin
					res_q.res_den  <= div_quo[DEN_BITS-1:0];
					res_q.is_empty <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

>>> hw/rtl/far_checker.sv
// Port-level checks for the fraction add and reduce unit.
// Depends on far_pkg; bound to fraction_add_reduce_unit below.
module far_checker import far_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after transfer");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_empty_den: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.is_empty == (result.res_den == '0)))
		else $error("empty flag disagrees with denominator");

	a_empty_num: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.is_empty) |-> (result.res_num == '0))
		else $error("empty result with nonzero numerator");

endmodule

bind fraction_add_reduce_unit far_checker u_far_checker (.*);

>>> bench/tb.sv
// Self-checking bench for fraction_add_reduce_unit: normalize and add-then-reduce.
// Holds a scoreboard class with its own gcd-based prediction and the drive tasks.
// Depends on far_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb import far_pkg::*;;

	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 200;
	localparam int RANDOM_ITEMS = 600;

	class fraction_scoreboard;
		result_t     expected_fracs[$];
		int unsigned errors;
		int unsigned n_checked;
		int unsigned n_empty;
		int unsigned n_add;

		function result_t reduce_fraction(item_t it);
			logic [63:0] n, d, x, y, t;
			logic        empty;
			result_t     r;
			if (it.operation == OP_NORMALIZE) begin
				n     = 64'(it.a_num);
				d     = 64'(it.a_den);
				empty = (it.a_den == '0);
			end else begin
				n     = 64'(it.a_num) * 64'(it.b_den) + 64'(it.a_den) * 64'(it.b_num);
				d     = 64'(it.a_den) * 64'(it.b_den);
				empty = (it.a_den == '0) || (it.b_den == '0);
			end
			r = '0;
			if (empty) begin
				r.is_empty = 1'b1;
				return r;
			end
			// zero numerator: divisor counts as 1
			x = n;
			y = d;
			if (x == 0) begin
				x = 1;
			end else begin
				while (y != 0) begin
					t = x % y;
					x = y;
					y = t;
				end
			end
			r.res_num = NUM_BITS'(n / x);
			r.res_den = DEN_BITS'(d / x);
			return r;
		endfunction

		function void note_item(item_t it);
			if (it.operation == OP_ADD)
				n_add++;
			expected_fracs.push_back(reduce_fraction(it));
		endfunction

		function void check_result(result_t got);
			result_t exp_r;
			if (expected_fracs.size() == 0) begin
				$display("%0t: unexpected result num=%0d den=%0d empty=%0b", $time,
					got.res_num, got.res_den, got.is_empty);
				errors++;
				return;
			end
			exp_r = expected_fracs.pop_front();
			n_checked++;
			if (exp_r.is_empty)
				n_empty++;
			if (got.res_num !== exp_r.res_num) begin
				$display("%0t: res_num mismatch expected %0d actual %0d", $time,
					exp_r.res_num, got.res_num);
				errors++;
			end
			if (got.res_den !== exp_r.res_den) begin
				$display("%0t: res_den mismatch expected %0d actual %0d", $time,
					exp_r.res_den, got.res_den);
				errors++;
			end
			if (got.is_empty !== exp_r.is_empty) begin
				$display("%0t: is_empty mismatch expected %0b actual %0b", $time,
					exp_r.is_empty, got.is_empty);
				errors++;
			end
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    done;
	result_t result;

	fraction_scoreboard sb;
	int unsigned        stall_cycles;
	logic               burst;

	fraction_add_reduce_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_fraction(logic op, logic [VALUE_BITS-1:0] an,
			logic [VALUE_BITS-1:0] ad, logic [VALUE_BITS-1:0] bn,
			logic [VALUE_BITS-1:0] bd);
		item_t it;
		int    gap;
		it.operation = op;
		it.a_num     = an;
		it.a_den     = ad;
		it.b_num     = bn;
		it.b_den     = bd;
		gap = burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		sb.note_item(it);
		@(negedge clk);
	endtask

	function automatic logic [VALUE_BITS-1:0] pick_value(int unsigned f);
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3:    return VALUE_BITS'($urandom_range(1, 40));
			4, 5, 6: return VALUE_BITS'(f * $urandom_range(1, 65535 / f));
			default: return VALUE_BITS'($urandom);
		endcase
	endfunction

	initial begin
		int unsigned f;
		sb           = new();
		arst_n       = 1'b0;
		start        = 1'b0;
		item         = '0;
		stall_cycles = 0;
		burst        = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_fraction(OP_NORMALIZE, 16'd0,     16'd0,     16'd0,     16'd0);
		send_fraction(OP_NORMALIZE, 16'd0,     16'd5,     16'd3,     16'd7);
		send_fraction(OP_NORMALIZE, 16'd5,     16'd0,     16'hffff,  16'hffff);
		send_fraction(OP_NORMALIZE, 16'hffff,  16'hffff,  16'd1,     16'd0);
		send_fraction(OP_NORMALIZE, 16'hffff,  16'd1,     16'd0,     16'd0);
		send_fraction(OP_NORMALIZE, 16'd1,     16'hffff,  16'hffff,  16'd1);
		send_fraction(OP_NORMALIZE, 16'd12,    16'd18,    16'd0,     16'd0);
		send_fraction(OP_NORMALIZE, 16'h8000,  16'h4000,  16'd0,     16'd0);
		send_fraction(OP_NORMALIZE, 16'd48000, 16'd64000, 16'd0,     16'd0);
		send_fraction(OP_ADD,       16'd3,     16'd0,     16'd5,     16'd7);
		send_fraction(OP_ADD,       16'd3,     16'd4,     16'd5,     16'd0);
		send_fraction(OP_ADD,       16'd0,     16'd0,     16'd0,     16'd0);
		send_fraction(OP_ADD,       16'd0,     16'd1,     16'd0,     16'd1);
		send_fraction(OP_ADD,       16'd0,     16'd7,     16'd0,     16'd9);
		send_fraction(OP_ADD,       16'hffff,  16'hffff,  16'hffff,  16'hffff);
		send_fraction(OP_ADD,       16'hffff,  16'd1,     16'hffff,  16'd1);
		send_fraction(OP_ADD,       16'd1,     16'hffff,  16'd1,     16'hffff);
		send_fraction(OP_ADD,       16'hffff,  16'hfffe,  16'hfffd,  16'hffff);
		send_fraction(OP_ADD,       16'd1,     16'd2,     16'd1,     16'd3);
		send_fraction(OP_ADD,       16'd1,     16'd6,     16'd1,     16'd3);
		send_fraction(OP_ADD,       16'd3,     16'd4,     16'd0,     16'd4);
		send_fraction(OP_ADD,       16'd1,     16'd2,     16'd1,     16'd2);
		send_fraction(OP_ADD,       16'h5555,  16'haaaa,  16'haaaa,  16'h5555);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 50 == 0)
				burst = ($urandom_range(0, 3) == 0);
			f = $urandom_range(1, 300);
			send_fraction(logic'($urandom_range(0, 1)), pick_value(f), pick_value(f),
				pick_value(f), pick_value(f));
		end
		start <= 1'b0;

		while (sb.expected_fracs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results (%0d add, %0d normalize), %0d of them empty.",
			sb.n_checked, sb.n_add, sb.n_checked - sb.n_add, sb.n_empty);
		$display("Mismatches and stray results: %0d", sb.errors);
		if (sb.errors == 0 && sb.expected_fracs.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/far_pkg.sv
hw/rtl/far_div.sv
hw/rtl/fraction_add_reduce_unit.sv
hw/rtl/far_checker.sv
bench/tb.sv
